// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files of the contrast enhancer; lce_stats uses them.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define LCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define LCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lce_pkg.sv =====
// Shared types and constants for the local contrast enhancer.
// No dependencies; used by the top level, lce_front, lce_stats, lce_isqrt and lce_gain.
package lce_pkg;

  localparam int HALF       = 4;
  localparam int SPAN       = 2 * HALF;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int S_W   = 14;  // window sum, max 64*255
  localparam int Q_W   = 22;  // window sum of squares
  localparam int CS_W  = 11;  // column sum
  localparam int CQ_W  = 19;  // column sum of squares
  localparam int VAR_W = 28;  // 64*Q - S*S
  localparam int SD_W  = 11;  // deviation, 3 fraction bits
  localparam int G_W   = 12;  // gain, Q2.10

  localparam int MIN_WIDTH = 8;
  localparam int ROW_MAX   = 1023;

  localparam int SD_LO   = 160;
  localparam int SD_HI   = 480;
  localparam int K_LO    = 12800;
  localparam int K_HI    = 51200;
  localparam int GN_LO   = 6144 * K_LO;
  localparam int GN_HI   = 6144 * K_HI;
  localparam int G_UNITY = 1024;

  localparam logic [10:0] RST_LINE_WIDTH    = 11'd640;
  localparam logic [9:0]  RST_REGION_LEFT   = 10'd0;
  localparam logic [9:0]  RST_REGION_TOP    = 10'd0;
  localparam logic [9:0]  RST_REGION_RIGHT  = 10'd1023;
  localparam logic [9:0]  RST_REGION_BOTTOM = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH    = 3'd0,
    CFG_REGION_LEFT   = 3'd1,
    CFG_REGION_TOP    = 3'd2,
    CFG_REGION_RIGHT  = 3'd3,
    CFG_REGION_BOTTOM = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             start_of_frame;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [PIX_W-1:0] out_value;
  } out_t;

  // centre position and flags leaving the line buffer
  typedef struct packed {
    logic             emit;
    logic             enh;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pos_t;

  // what travels with a result through the math pipeline
  typedef struct packed {
    logic             enh;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [PIX_W-1:0] p;
    logic [S_W-1:0]   s;
  } tag_t;

endpackage

// ===== hdl/lce_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload types come from lce_pkg at the instance.
interface lce_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/local_contrast_enhance.sv =====
// Local contrast enhancer, top level: config registers, pipeline stall, output math.
// Depends on lce_pkg, lce_stream_if, lce_front, lce_stats, lce_isqrt, lce_gain.
//
// Usage:
//   in_ch carries raster grey pixels; start_of_frame on a transaction puts that
//   pixel at column 0, row 0. out_ch carries one transaction per pixel once the
//   8x8 window around centre (col-3, row-3) is complete: centre position and the
//   enhanced value, 0 outside the region or in the border (left/top 4, right 3 px).
//   cfg_we/cfg_idx/cfg_wdata write line_width and the region bounds; write them
//   only while the pipeline is empty.
//   Throughput: one pixel per clock while out_ch does not stall. The pipeline
//   has 22 register stages, most of them in the variance, square root
//   (6 stages) and gain divider (6 stages) pipeline.
//   Reset clears the counters, window sums and valid bits; config returns to
//   width 640 and the full region. Line memory contents stay undefined.
//   When out_ch stalls the whole pipeline holds, in_ch.ready drops, and nothing
//   is lost or repeated; in_ch stays open while the output slot can move.
module local_contrast_enhance #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lce_stream_if.sink                         in_ch,
  lce_stream_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [lce_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lce_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  logic [10:0] cfg_width_r;
  logic [9:0]  cfg_left_r, cfg_top_r, cfg_right_r, cfg_bottom_r;
  logic        en;

  logic                                    fr_v;
  logic [lce_pkg::SPAN*lce_pkg::PIX_W-1:0] fr_col;
  lce_pkg::pos_t                           fr_pos;
  logic                                    st_v;
  logic [lce_pkg::VAR_W-1:0]               st_var;
  lce_pkg::tag_t                           st_tag;
  logic                                    sq_v;
  logic [lce_pkg::SD_W-1:0]                sq_sd;
  lce_pkg::tag_t                           sq_tag;
  logic                                    gn_v;
  logic [lce_pkg::G_W-1:0]                 gn_g;
  lce_pkg::tag_t                           gn_tag;

  logic signed [14:0] diff;
  logic signed [28:0] m_nxt, sterm, num;
  logic [7:0]         val;
  logic               f0_v_r, o_v_r;
  logic signed [28:0] f0_m_r;
  lce_pkg::tag_t      f0_tag_r;
  lce_pkg::out_t      o_data_r;

  assign en          = !o_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= lce_pkg::RST_LINE_WIDTH;
      cfg_left_r   <= lce_pkg::RST_REGION_LEFT;
      cfg_top_r    <= lce_pkg::RST_REGION_TOP;
      cfg_right_r  <= lce_pkg::RST_REGION_RIGHT;
      cfg_bottom_r <= lce_pkg::RST_REGION_BOTTOM;
    end else if (cfg_we) begin
      unique case (lce_pkg::cfg_idx_t'(cfg_idx))
        lce_pkg::CFG_LINE_WIDTH:    cfg_width_r  <= cfg_wdata;
        lce_pkg::CFG_REGION_LEFT:   cfg_left_r   <= cfg_wdata[9:0];
        lce_pkg::CFG_REGION_TOP:    cfg_top_r    <= cfg_wdata[9:0];
        lce_pkg::CFG_REGION_RIGHT:  cfg_right_r  <= cfg_wdata[9:0];
        lce_pkg::CFG_REGION_BOTTOM: cfg_bottom_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  lce_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (in_ch.valid),
    .in_pix     (in_ch.data.pixel_value),
    .in_sof     (in_ch.data.start_of_frame),
    .cfg_width  (cfg_width_r),
    .cfg_left   (cfg_left_r),
    .cfg_top    (cfg_top_r),
    .cfg_right  (cfg_right_r),
    .cfg_bottom (cfg_bottom_r),
    .out_v      (fr_v),
    .out_col    (fr_col),
    .out_pos    (fr_pos)
  );

  lce_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (fr_v),
    .in_col  (fr_col),
    .in_pos  (fr_pos),
    .out_v   (st_v),
    .out_var (st_var),
    .out_tag (st_tag)
  );

  // floor(isqrt(64*var)/64) equals isqrt(var/64)
  lce_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (st_v),
    .in_x     (st_var[lce_pkg::VAR_W-1:6]),
    .in_tag   (st_tag),
    .out_v    (sq_v),
    .out_root (sq_sd),
    .out_tag  (sq_tag)
  );

  lce_gain u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (sq_v),
    .in_sd   (sq_sd),
    .in_tag  (sq_tag),
    .out_v   (gn_v),
    .out_g   (gn_g),
    .out_tag (gn_tag)
  );

  always_comb begin
    diff  = $signed({1'b0, gn_tag.p, 6'b0}) - $signed({1'b0, gn_tag.s});
    m_nxt = $signed({1'b0, gn_g}) * diff;
    sterm = $signed({5'b0, f0_tag_r.s, 10'b0});
    num   = f0_m_r + sterm;
    // num / 65536 truncated toward zero, clipped to 255; a quotient below zero keeps the pixel
    if (!f0_tag_r.enh) begin
      val = '0;
    end else if (num >= 29'sd16777216) begin
      val = 8'd255;
    end else if (num >= 29'sd0) begin
      val = num[23:16];
    end else if (num > -29'sd65536) begin
      val = '0;
    end else begin
      val = f0_tag_r.p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      f0_v_r <= gn_v;
      o_v_r  <= f0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_m_r   <= m_nxt;
      f0_tag_r <= gn_tag;
      o_data_r <= '{out_x: f0_tag_r.x, out_y: f0_tag_r.y, out_value: val};
    end
  end

  assign out_ch.valid = o_v_r;
  assign out_ch.data  = o_data_r;
endmodule

// ===== hdl/lce_front.sv =====
// Line buffer front end: raster counters, region test, line memory, column build.
// Depends on lce_pkg.
module lce_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_v,
  input  logic [lce_pkg::PIX_W-1:0]              in_pix,
  input  logic                                   in_sof,
  input  logic [10:0]                            cfg_width,
  input  logic [lce_pkg::POS_W-1:0]              cfg_left,
  input  logic [lce_pkg::POS_W-1:0]              cfg_top,
  input  logic [lce_pkg::POS_W-1:0]              cfg_right,
  input  logic [lce_pkg::POS_W-1:0]              cfg_bottom,
  output logic                                   out_v,
  output logic [lce_pkg::SPAN*lce_pkg::PIX_W-1:0] out_col,
  output lce_pkg::pos_t                          out_pos
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (lce_pkg::SPAN - 1) * lce_pkg::PIX_W;

  logic [CW-1:0] col_r, col_nxt, col;
  logic [9:0]    row_r, row_nxt, row;
  logic [12:0]   width, col13, cx13, lo_x, hi_x;
  logic [9:0]    cy, lo_y;
  logic          acc, emit, enh;

  logic [LW-1:0] mem [MAX_WIDTH];
  logic [LW-1:0] rd_q_r, byp_d_r, word, wr_word;
  logic          byp_r;

  logic                            s1_v_r;
  logic [CW-1:0]                   s1_col_r;
  logic [lce_pkg::PIX_W-1:0]       s1_pix_r;
  lce_pkg::pos_t                   s1_pos_r;

  logic                                    s2_v_r;
  logic [lce_pkg::SPAN*lce_pkg::PIX_W-1:0] s2_col_r;
  lce_pkg::pos_t                           s2_pos_r;

  always_comb begin
    acc = in_v & en;
    if (cfg_width < 11'(lce_pkg::MIN_WIDTH)) begin
      width = 13'(lce_pkg::MIN_WIDTH);
    end else if (13'(cfg_width) > 13'(MAX_WIDTH)) begin
      width = 13'(MAX_WIDTH);
    end else begin
      width = 13'(cfg_width);
    end
    col   = in_sof ? '0 : col_r;
    row   = in_sof ? '0 : row_r;
    col13 = 13'(col);
    cx13  = col13 - 13'(lce_pkg::HALF - 1);
    cy    = row - 10'(lce_pkg::HALF - 1);
    emit  = (col13 >= 13'(lce_pkg::HALF - 1)) && (row >= 10'(lce_pkg::HALF - 1));
    lo_x  = (cfg_left > 10'(lce_pkg::HALF)) ? 13'(cfg_left) : 13'(lce_pkg::HALF);
    lo_y  = (cfg_top > 10'(lce_pkg::HALF)) ? cfg_top : 10'(lce_pkg::HALF);
    hi_x  = (13'(cfg_right) < width - 13'(lce_pkg::HALF)) ? 13'(cfg_right)
                                                           : width - 13'(lce_pkg::HALF);
    enh   = (cx13 >= lo_x) && (cy >= lo_y) && (cx13 <= hi_x) && (cy <= cfg_bottom);
    if (col13 + 13'd1 >= width) begin
      col_nxt = '0;
      row_nxt = (row == 10'(lce_pkg::ROW_MAX)) ? row : row + 10'd1;
    end else begin
      col_nxt = col + CW'(1);
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // row i of the column is line store i; the new pixel is the bottom row
  always_comb begin
    word    = byp_r ? byp_d_r : rd_q_r;
    wr_word = {s1_pix_r, word[LW-1:lce_pkg::PIX_W]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_q_r <= mem[col];
    end
    if (en && s1_v_r) begin
      mem[s1_col_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      byp_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      // back-to-back hit on the same column: the read saw the old word
      byp_r  <= s1_v_r && in_v && (col == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_d_r  <= wr_word;
      s1_col_r <= col;
      s1_pix_r <= in_pix;
      s1_pos_r <= '{emit: emit, enh: enh, x: cx13[9:0], y: cy};
      s2_col_r <= {s1_pix_r, word};
      s2_pos_r <= s1_pos_r;
    end
  end

  assign out_v   = s2_v_r;
  assign out_col = s2_col_r;
  assign out_pos = s2_pos_r;
endmodule

// ===== hdl/lce_stats.sv =====
// Window statistics: column sums, window sum and sum of squares, variance.
// Depends on lce_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lce_stats (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_v,
  input  logic [lce_pkg::SPAN*lce_pkg::PIX_W-1:0] in_col,
  input  lce_pkg::pos_t                           in_pos,
  output logic                                    out_v,
  output logic [lce_pkg::VAR_W-1:0]               out_var,
  output lce_pkg::tag_t                           out_tag
);
  localparam int SPAN = lce_pkg::SPAN;
  localparam int PW   = lce_pkg::PIX_W;

  logic [PW-1:0]            p_hist_r [lce_pkg::HALF-1];
  logic [lce_pkg::CS_W-1:0] cs_hist_r [SPAN-1];
  logic [lce_pkg::CQ_W-1:0] cq_hist_r [SPAN-1];
  logic [lce_pkg::S_W-1:0]  s_nxt;
  logic [lce_pkg::Q_W-1:0]  q_nxt;

  logic [2*PW-1:0]          sq [SPAN];
  logic [lce_pkg::CS_W-1:0] cs;
  logic [lce_pkg::CQ_W-1:0] cq;

  logic                     a_v_r, b_v_r, c_v_r, d_v_r;
  lce_pkg::pos_t            a_pos_r, b_pos_r, c_pos_r;
  logic [2*PW-1:0]          a_sq_r [SPAN];
  logic [lce_pkg::CS_W-1:0] a_cs_r, b_cs_r;
  logic [lce_pkg::CQ_W-1:0] b_cq_r;
  logic [PW-1:0]            a_p_r, b_p_r, c_p_r;
  logic [lce_pkg::S_W-1:0]  c_s_r;
  logic [lce_pkg::Q_W-1:0]  c_q_r;
  logic [lce_pkg::VAR_W-1:0] q64_c, ssq_c, d_var_r;
  lce_pkg::tag_t            d_tag_r;

  always_comb begin
    cs = '0;
    for (int i = 0; i < SPAN; i++) begin
      sq[i] = in_col[PW*i +: PW] * in_col[PW*i +: PW];
      cs    = cs + lce_pkg::CS_W'(in_col[PW*i +: PW]);
    end
    cq = '0;
    for (int i = 0; i < SPAN; i++) begin
      cq = cq + lce_pkg::CQ_W'(a_sq_r[i]);
    end
    // window sums: newest column plus the seven before it
    s_nxt = lce_pkg::S_W'(b_cs_r);
    q_nxt = lce_pkg::Q_W'(b_cq_r);
    for (int i = 0; i < SPAN - 1; i++) begin
      s_nxt = s_nxt + lce_pkg::S_W'(cs_hist_r[i]);
      q_nxt = q_nxt + lce_pkg::Q_W'(cq_hist_r[i]);
    end
    q64_c = {c_q_r, 6'b0};
    ssq_c = c_s_r * c_s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      for (int i = 0; i < lce_pkg::HALF - 1; i++) begin
        p_hist_r[i] <= '0;
      end
      for (int i = 0; i < SPAN - 1; i++) begin
        cs_hist_r[i] <= '0;
        cq_hist_r[i] <= '0;
      end
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r & b_pos_r.emit;
      d_v_r <= c_v_r;
      if (in_v) begin
        p_hist_r[0] <= in_col[PW*lce_pkg::HALF +: PW];
        for (int i = 1; i < lce_pkg::HALF - 1; i++) begin
          p_hist_r[i] <= p_hist_r[i-1];
        end
      end
      if (b_v_r) begin
        cs_hist_r[0] <= b_cs_r;
        cq_hist_r[0] <= b_cq_r;
        for (int i = 1; i < SPAN - 1; i++) begin
          cs_hist_r[i] <= cs_hist_r[i-1];
          cq_hist_r[i] <= cq_hist_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pos_r <= in_pos;
      a_sq_r  <= sq;
      a_cs_r  <= cs;
      // centre column entered three columns before this one
      a_p_r   <= p_hist_r[lce_pkg::HALF-2];
      b_pos_r <= a_pos_r;
      b_cs_r  <= a_cs_r;
      b_cq_r  <= cq;
      b_p_r   <= a_p_r;
      c_pos_r <= b_pos_r;
      c_s_r   <= s_nxt;
      c_q_r   <= q_nxt;
      c_p_r   <= b_p_r;
      d_var_r <= q64_c - ssq_c;
      d_tag_r <= '{enh: c_pos_r.enh, x: c_pos_r.x, y: c_pos_r.y, p: c_p_r, s: c_s_r};
    end
  end

  assign out_v   = d_v_r;
  assign out_var = d_var_r;
  assign out_tag = d_tag_r;

  `LCE_ASSERT_IMP(a_sum_bound, c_v_r && c_pos_r.enh, c_s_r <= 14'd16320, "window sum out of range")
  `LCE_ASSERT_IMP(a_var_nonneg, c_v_r && c_pos_r.enh, q64_c >= ssq_c, "negative window variance")
  `LCE_ASSERT_NXT(a_stall_hold, !en, $stable(c_v_r) && $stable(d_v_r), "valid bits moved in stall")
endmodule

// ===== hdl/lce_isqrt.sv =====
// Pipelined integer square root, two root bits per stage.
// Depends on lce_pkg.
module lce_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [21:0]               in_x,
  input  lce_pkg::tag_t             in_tag,
  output logic                      out_v,
  output logic [lce_pkg::SD_W-1:0]  out_root,
  output lce_pkg::tag_t             out_tag
);
  localparam int XW  = 22;
  localparam int RW  = lce_pkg::SD_W;
  localparam int BPS = 2;
  localparam int NST = (RW + BPS - 1) / BPS;

  logic          v_r    [NST];
  logic [XW-1:0] rem_r  [NST];
  logic [RW-1:0] root_r [NST];
  lce_pkg::tag_t tag_r  [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic          v_i;
    logic [XW-1:0] rem_i, rem_o;
    logic [RW-1:0] root_i, root_o;
    lce_pkg::tag_t tag_i;

    if (k == 0) begin : g_head
      assign v_i    = in_v;
      assign rem_i  = in_x;
      assign root_i = '0;
      assign tag_i  = in_tag;
    end else begin : g_body
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign tag_i  = tag_r[k-1];
    end

    // rem_o holds x - root^2; a root bit is set when its trial fits
    always_comb begin
      logic [XW+1:0] trial;
      int            b;
      rem_o  = rem_i;
      root_o = root_i;
      trial  = '0;
      for (int j = 0; j < BPS; j++) begin
        b = RW - 1 - (BPS * k + j);
        if (b >= 0) begin
          trial = ((XW+2)'(root_o) << (b + 1)) + ((XW+2)'(1) << (2 * b));
          if ((XW+2)'(rem_o) >= trial) begin
            rem_o  = rem_o - XW'(trial);
            root_o = root_o | (RW'(1) << b);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_o;
        root_r[k] <= root_o;
        tag_r[k]  <= tag_i;
      end
    end
  end

  assign out_v    = v_r[NST-1];
  assign out_root = root_r[NST-1];
  assign out_tag  = tag_r[NST-1];
endmodule

// ===== hdl/lce_gain.sv =====
// Gain curve: squared distance, denominator, pipelined rounding divider.
// Depends on lce_pkg.
module lce_gain (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [lce_pkg::SD_W-1:0] in_sd,
  input  lce_pkg::tag_t            in_tag,
  output logic                     out_v,
  output logic [lce_pkg::G_W-1:0]  out_g,
  output lce_pkg::tag_t            out_tag
);
  localparam int NW  = 29;
  localparam int DW  = 20;
  localparam int GW  = lce_pkg::G_W;
  localparam int BPS = 2;
  localparam int NST = GW / BPS;

  logic          big, lo;
  logic [8:0]    d;
  logic [18:0]   den;
  logic [NW-1:0] num;

  logic          g0_v_r, g0_big_r, g0_lo_r;
  logic [17:0]   g0_dd_r;
  lce_pkg::tag_t g0_tag_r;
  logic          g1_v_r, g1_big_r;
  logic [NW-1:0] g1_rem_r;
  logic [DW-1:0] g1_dv_r;
  lce_pkg::tag_t g1_tag_r;

  logic          v_r   [NST];
  logic          big_r [NST];
  logic [NW-1:0] rem_r [NST];
  logic [DW-1:0] dv_r  [NST];
  logic [GW-1:0] q_r   [NST];
  lce_pkg::tag_t tag_r [NST];

  always_comb begin
    big = in_sd >= lce_pkg::SD_W'(lce_pkg::SD_HI);
    lo  = in_sd < lce_pkg::SD_W'(lce_pkg::SD_LO);
    d   = lo ? 9'(lce_pkg::SD_W'(lce_pkg::SD_LO) - in_sd)
             : 9'(in_sd - lce_pkg::SD_W'(lce_pkg::SD_LO));
    den = 19'(g0_dd_r) + (g0_lo_r ? 19'(lce_pkg::K_LO) : 19'(lce_pkg::K_HI));
    // rounding: (2*3072*k + den) / (2*den)
    num = (g0_lo_r ? NW'(lce_pkg::GN_LO) : NW'(lce_pkg::GN_HI)) + NW'(den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g0_v_r <= 1'b0;
      g1_v_r <= 1'b0;
    end else if (en) begin
      g0_v_r <= in_v;
      g1_v_r <= g0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g0_big_r <= big;
      g0_lo_r  <= lo;
      g0_dd_r  <= d * d;
      g0_tag_r <= in_tag;
      g1_big_r <= g0_big_r;
      g1_rem_r <= num;
      g1_dv_r  <= {den, 1'b0};
      g1_tag_r <= g0_tag_r;
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_div
    logic          v_i, big_i;
    logic [NW-1:0] rem_i, rem_o;
    logic [DW-1:0] dv_i;
    logic [GW-1:0] q_i, q_o;
    lce_pkg::tag_t tag_i;

    if (k == 0) begin : g_head
      assign v_i   = g1_v_r;
      assign big_i = g1_big_r;
      assign rem_i = g1_rem_r;
      assign dv_i  = g1_dv_r;
      assign q_i   = '0;
      assign tag_i = g1_tag_r;
    end else begin : g_body
      assign v_i   = v_r[k-1];
      assign big_i = big_r[k-1];
      assign rem_i = rem_r[k-1];
      assign dv_i  = dv_r[k-1];
      assign q_i   = q_r[k-1];
      assign tag_i = tag_r[k-1];
    end

    always_comb begin
      logic [31:0] trial;
      int          b;
      rem_o = rem_i;
      q_o   = q_i;
      trial = '0;
      for (int j = 0; j < BPS; j++) begin
        b     = GW - 1 - (BPS * k + j);
        trial = 32'(dv_i) << b;
        if (32'(rem_o) >= trial) begin
          rem_o = rem_o - NW'(trial);
          q_o   = q_o | (GW'(1) << b);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        big_r[k] <= big_i;
        rem_r[k] <= rem_o;
        dv_r[k]  <= dv_i;
        q_r[k]   <= q_o;
        tag_r[k] <= tag_i;
      end
    end
  end

  assign out_v   = v_r[NST-1];
  assign out_g   = big_r[NST-1] ? GW'(lce_pkg::G_UNITY) : q_r[NST-1];
  assign out_tag = tag_r[NST-1];
endmodule
